FILE: rtl/core/pdst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdst_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int COORD_BITS  = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POINT_W     = 2 * COORD_BITS;
  localparam int SERIAL_W    = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    logic                is_new;
    logic                table_full;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pdst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pdst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pdst_search.sv
`timescale 1ns / 1ps
`default_nettype none

module pdst_search
  import pdst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_x,
  input  wire logic [COORD_BITS-1:0] in_y,
  output logic                       res_valid,
  output result_t                    res,
  input  wire logic                  res_take,
  output logic                       mem_wr_en,
  output logic      [ADDR_W-1:0]     mem_wr_addr,
  output logic      [POINT_W-1:0]    mem_wr_data,
  output logic                       mem_rd_en,
  output logic      [ADDR_W-1:0]     mem_rd_addr,
  input  wire logic [POINT_W-1:0]    mem_rd_data
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [POINT_W-1:0]  point_r, point_nxt;
  result_t             res_r, res_nxt;
  logic [CNT_W-1:0]    idx_plus1;
  logic                is_full;

  assign idx_plus1 = CNT_W'({1'b0, idx_r}) + CNT_W'(1);
  assign is_full   = (count_r == CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    point_r <= point_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    point_nxt   = point_r;
    res_nxt     = res_r;
    in_stall    = 1'b1;
    res_valid   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = count_r[ADDR_W-1:0];
    mem_wr_data = point_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          point_nxt = {in_x, in_y};
          idx_nxt   = '0;
          if (count_r == '0) begin
            // empty table: append directly
            mem_wr_en   = 1'b1;
            mem_wr_data = {in_x, in_y};
            count_nxt   = CNT_W'(1);
            res_nxt     = '{serial: SERIAL_W'(1), is_new: 1'b1, table_full: 1'b0};
            state_nxt   = ST_DONE;
          end else begin
            mem_rd_en = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (mem_rd_data == point_r) begin
          res_nxt   = '{serial: SERIAL_W'(idx_plus1), is_new: 1'b0, table_full: 1'b0};
          state_nxt = ST_DONE;
        end else if (idx_plus1 == count_r) begin
          if (is_full) begin
            res_nxt = '{serial: '0, is_new: 1'b0, table_full: 1'b1};
          end else begin
            mem_wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            res_nxt   = '{serial: SERIAL_W'(count_r + CNT_W'(1)), is_new: 1'b1,
                          table_full: 1'b0};
          end
          state_nxt = ST_DONE;
        end else begin
          idx_nxt     = idx_plus1[ADDR_W-1:0];
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_plus1[ADDR_W-1:0];
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res = res_r;

endmodule

`default_nettype wire

FILE: rtl/core/point_dedup_serial_table.sv
// Point dedup table: each input transaction carries one signed (x, y) point.
// The stored points are searched in insertion order; a hit returns the
// entry's 1-based serial, a miss appends the point and returns the new
// count, and a miss on a full table (1024 entries) returns serial 0 with
// table_full set. One transaction is processed at a time: the stored entries
// are compared in turn, up to and including a hit, or all of them on a miss.
// The scan uses the single read port of the point memory, which is read one
// entry per cycle. A registered output stage holds a finished result so the
// next point can be accepted while it waits. No initialization pass is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module point_dedup_serial_table
  import pdst_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [SERIAL_W-1:0]   out_serial,
  output logic                              out_is_new,
  output logic                              out_table_full
);

  logic                res_valid;
  result_t             res;
  logic                res_take;
  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  logic [POINT_W-1:0]  mem_wr_data;
  logic                mem_rd_en;
  logic [ADDR_W-1:0]   mem_rd_addr;
  logic [POINT_W-1:0]  mem_rd_data;
  logic                out_valid_r;
  result_t             out_r;

  pdst_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_x        (in_point_x),
    .in_y        (in_point_y),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  pdst_ram #(
    .WIDTH (POINT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_serial     = out_r.serial;
  assign out_is_new     = out_r.is_new;
  assign out_table_full = out_r.table_full;

endmodule

`default_nettype wire

FILE: bench/point_dedup_serial_table_test.sv
`timescale 1ns / 1ps

module point_dedup_serial_table_test
  import pdst_pkg::*;
;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] in_point_x = '0;
  logic signed [COORD_BITS-1:0] in_point_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic        [SERIAL_W-1:0]   out_serial;
  logic                         out_is_new;
  logic                         out_table_full;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatch_count = 0;

  // shadow copy of the point table
  logic [COORD_BITS-1:0] stored_x [TABLE_DEPTH];
  logic [COORD_BITS-1:0] stored_y [TABLE_DEPTH];
  int                    stored_count = 0;

  result_t pending_results[$];

  point_dedup_serial_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_serial     (out_serial),
    .out_is_new     (out_is_new),
    .out_table_full (out_table_full)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  function automatic int find_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
    for (int i = 0; i < stored_count; i++) begin
      if (stored_x[i] == x && stored_y[i] == y) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic result_t predict_serial(logic [COORD_BITS-1:0] x,
                                             logic [COORD_BITS-1:0] y);
    result_t r;
    int      idx;
    r   = '0;
    idx = find_point(x, y);
    if (idx >= 0) begin
      r.serial = SERIAL_W'(idx + 1);
    end else if (stored_count >= TABLE_DEPTH) begin
      r.table_full = 1'b1;
    end else begin
      stored_x[stored_count] = x;
      stored_y[stored_count] = y;
      stored_count++;
      r.serial = SERIAL_W'(stored_count);
      r.is_new = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result serial=%0d is_new=%b full=%b",
                                  out_serial, out_is_new, out_table_full));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_serial !== exp_r.serial || out_is_new !== exp_r.is_new ||
            out_table_full !== exp_r.table_full) begin
          report_mismatch($sformatf("got serial=%0d is_new=%b full=%b, exp %0d %b %b",
                                    out_serial, out_is_new, out_table_full,
                                    exp_r.serial, exp_r.is_new, exp_r.table_full));
        end
      end
    end
  end

  // called and returns at a falling edge; valid stays high into the next transaction
  task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_serial(x, y));
    @(negedge clk);
  endtask

  task automatic make_fresh_point(output logic [COORD_BITS-1:0] x,
                                  output logic [COORD_BITS-1:0] y);
    do begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
    end while (find_point(x, y) >= 0);
  endtask

  task automatic test_directed_points();
    logic [2*COORD_BITS-1:0] pts [18];
    pts = '{
      {16'h0000, 16'h0000}, {16'h0000, 16'h0000}, {16'h8000, 16'h8000},
      {16'h7fff, 16'h7fff}, {16'h8000, 16'h7fff}, {16'h7fff, 16'h8000},
      {16'hffff, 16'hffff}, {16'hffff, 16'h0000}, {16'h0000, 16'hffff},
      {16'h0001, 16'h0000}, {16'h0000, 16'h0001}, {16'h8000, 16'h8000},
      {16'h7fff, 16'h8000}, {16'h0000, 16'hffff}, {16'hffff, 16'hffff},
      {16'h5555, 16'haaaa}, {16'haaaa, 16'h5555}, {16'h5555, 16'haaaa}
    };
    foreach (pts[i]) begin
      send_point(pts[i][2*COORD_BITS-1:COORD_BITS], pts[i][COORD_BITS-1:0]);
    end
  endtask

  // mix of repeats, one-bit near misses and fresh points
  task automatic test_random_points(input int n);
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    int                    idx;
    int                    pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      idx  = $urandom_range(stored_count - 1);
      if (stored_count > 0 && pick < 45) begin
        x = stored_x[idx];
        y = stored_y[idx];
      end else if (stored_count > 0 && pick < 70) begin
        x = stored_x[idx];
        y = stored_y[idx];
        if ($urandom_range(1)) x[$urandom_range(COORD_BITS - 1)] ^= 1'b1;
        else y[$urandom_range(COORD_BITS - 1)] ^= 1'b1;
      end else begin
        make_fresh_point(x, y);
      end
      send_point(x, y);
    end
  endtask

  task automatic test_fill_table();
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    while (stored_count < TABLE_DEPTH) begin
      make_fresh_point(x, y);
      send_point(x, y);
    end
  endtask

  task automatic test_full_table(input int n);
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    int                    idx;
    send_point(stored_x[0], stored_y[0]);
    send_point(stored_x[TABLE_DEPTH-1], stored_y[TABLE_DEPTH-1]);
    make_fresh_point(x, y);
    send_point(x, y);
    x = stored_x[TABLE_DEPTH-1] ^ 16'h0001;
    send_point(x, stored_y[TABLE_DEPTH-1]);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1)) begin
        idx = $urandom_range(TABLE_DEPTH - 1);
        send_point(stored_x[idx], stored_y[idx]);
      end else begin
        make_fresh_point(x, y);
        send_point(x, y);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 28;
    rx_idle_pct = 75;
    test_directed_points();
    test_random_points(200);

    tx_idle_pct = 75;
    rx_idle_pct = 28;
    test_random_points(200);
    test_fill_table();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_full_table(40);

    drain_results();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
